// ===== hdl/assert_macros.svh =====
// assertion macros shared by the lookup block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define RKLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a condition that must be followed by another in the next cycle
`define RKLI_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ===== hdl/rkli_pkg.sv =====
// types, codes and defaults of the row keyed interpolation lookup
package rkli_pkg;

    localparam int MAX_ROWS_DEF    = 128;
    localparam int MAX_COLUMNS_DEF = 16;

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // request types
    localparam logic [1:0] REQ_AGE    = 2'd0;
    localparam logic [1:0] REQ_BP     = 2'd1;
    localparam logic [1:0] REQ_ENTRY  = 2'd2;
    localparam logic [1:0] REQ_LOOKUP = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [6:0]         row_slot;
        logic [3:0]         column_slot;
        logic signed [31:0] write_data;
        logic [7:0]         query_age;
        logic signed [31:0] query_value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ROW_RD,
        S_ROW_CMP,
        S_BP_FIRST,
        S_BP_LAST,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EXACT_RD,
        S_EXACT,
        S_Y1_RD,
        S_Y2_RD,
        S_MUL,
        S_DIV,
        S_SUM,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        BP_FIRST,
        BP_LAST,
        BP_SCAN
    } bp_sel_t;

    typedef enum logic [2:0] {
        RES_WRITE,
        RES_EMPTY,
        RES_NOT_FOUND,
        RES_ENTRY,
        RES_INTERP
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      wr;
        logic      row_init;
        logic      row_rd;
        logic      row_next;
        logic      bp_rd;
        bp_sel_t   bp_sel;
        logic      save_x1;
        logic      save_x2;
        logic      col_first;
        logic      col_last;
        logic      col_one;
        logic      col_next;
        logic      ent_rd;
        logic      ent_prev;
        logic      save_y1;
        logic      mul;
        logic      div_step;
        logic      res_set;
        res_kind_t res_kind;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       empty;
        logic       age_match;
        logic       row_last;
        logic       v_le_bp;
        logic       v_ge_bp;
        logic       v_eq_bp;
        logic       div_done;
    } dp_status_t;

endpackage

// ===== hdl/rkli_dp.sv =====
// datapath: stores, search registers, multiplier, divider and result registers
module rkli_dp import rkli_pkg::*; #(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  req_item_t  req,
    input  dp_cmd_t    cmd,
    output dp_status_t stat,
    output rsp_item_t  rsp
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ENT_N  = MAX_ROWS * MAX_COLUMNS;
    localparam int ENT_W  = $clog2(ENT_N);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);

    logic [7:0] age_mem [MAX_ROWS];
    logic signed [31:0] bp_mem [MAX_COLUMNS];
    logic signed [31:0] ent_mem [ENT_N];

    logic [7:0] rows_reg;
    logic [4:0] cols_reg;
    logic [RCNT_W-1:0] nr;
    logic [CCNT_W-1:0] nc;

    req_item_t item_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [7:0] age_q;
    logic signed [31:0] bp_q;
    logic signed [31:0] ent_q;
    logic signed [31:0] x1_reg, x2_reg, y1_reg;
    logic [63:0] dq_reg;
    logic [32:0] rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [31:0] gap_reg;
    logic neg_reg;
    logic [1:0] res_status_reg;
    logic signed [31:0] res_value_reg;
    rsp_item_t out_reg;

    logic [8:0] rslot_ext;
    logic [6:0] cslot_ext;
    logic rslot_ok, cslot_ok;
    logic [8:0] rows_clip;
    logic [6:0] cols_clip;
    logic [COL_W-1:0] bp_addr;
    logic [COL_W-1:0] ent_col;
    logic [ENT_W-1:0] ent_rd_addr, ent_wr_addr;
    logic signed [32:0] dy;
    logic [32:0] mag_dy;
    logic [32:0] dx;
    logic [32:0] gap_w;
    logic [64:0] prod;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic signed [33:0] sum;
    logic signed [31:0] sum_sat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            cols_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data[4:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // clip counts to the store sizes
    always_comb
    begin
        rows_clip = (9'(rows_reg) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(rows_reg);
        cols_clip = (7'(cols_reg) > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : 7'(cols_reg);
        nr = RCNT_W'(rows_clip);
        nc = CCNT_W'(cols_clip);
    end

    // write slot decode
    assign rslot_ext   = 9'(req.row_slot);
    assign cslot_ext   = 7'(req.column_slot);
    assign rslot_ok    = rslot_ext < 9'(MAX_ROWS);
    assign cslot_ok    = cslot_ext < 7'(MAX_COLUMNS);
    assign ent_wr_addr = ENT_W'(rslot_ext[ROW_W-1:0]) * ENT_W'(MAX_COLUMNS)
                       + ENT_W'(cslot_ext[COL_W-1:0]);

    // read address selection
    always_comb
    begin
        case (cmd.bp_sel)
            BP_FIRST: bp_addr = '0;
            BP_LAST:  bp_addr = COL_W'(nc - CCNT_W'(1));
            default:  bp_addr = col_reg;
        endcase
        ent_col     = cmd.ent_prev ? (col_reg - COL_W'(1)) : col_reg;
        ent_rd_addr = ENT_W'(row_reg) * ENT_W'(MAX_COLUMNS) + ENT_W'(ent_col);
    end

    // age store
    always_ff @(posedge clk)
    begin
        if (cmd.wr && req.req_type == REQ_AGE && rslot_ok)
            age_mem[rslot_ext[ROW_W-1:0]] <= req.write_data[7:0];
        if (cmd.row_rd)
            age_q <= age_mem[row_reg];
    end

    // breakpoint store
    always_ff @(posedge clk)
    begin
        if (cmd.wr && req.req_type == REQ_BP && cslot_ok)
            bp_mem[cslot_ext[COL_W-1:0]] <= req.write_data;
        if (cmd.bp_rd)
            bp_q <= bp_mem[bp_addr];
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (cmd.wr && req.req_type == REQ_ENTRY && rslot_ok && cslot_ok)
            ent_mem[ent_wr_addr] <= req.write_data;
        if (cmd.ent_rd)
            ent_q <= ent_mem[ent_rd_addr];
    end

    // search indexes and captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= req;
        if (cmd.row_init)
            row_reg <= '0;
        else if (cmd.row_next)
            row_reg <= row_reg + ROW_W'(1);
        if (cmd.col_first)
            col_reg <= '0;
        else if (cmd.col_last)
            col_reg <= COL_W'(nc - CCNT_W'(1));
        else if (cmd.col_one)
            col_reg <= COL_W'(1);
        else if (cmd.col_next)
            col_reg <= col_reg + COL_W'(1);
        if (cmd.save_x1)
            x1_reg <= bp_q;
        if (cmd.save_x2)
            x2_reg <= bp_q;
        if (cmd.save_y1)
            y1_reg <= ent_q;
    end

    // entry difference times offset, upper entry taken straight from the entry read
    always_comb
    begin
        dy     = 33'(ent_q) - 33'(y1_reg);
        mag_dy = dy[32] ? 33'(-dy) : 33'(dy);
        dx     = 33'(item_reg.query_value) - 33'(x1_reg);
        gap_w  = 33'(x2_reg) - 33'(x1_reg);
        prod   = mag_dy * 65'(dx[31:0]);
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg[31:0], dq_reg[63]};
        rem_sub = rem_sh - 33'(gap_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            dq_reg      <= prod[63:0];
            rem_reg     <= '0;
            gap_reg     <= gap_w[31:0];
            neg_reg     <= dy[32];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (rem_sh >= 33'(gap_reg))
            begin
                rem_reg <= rem_sub;
                dq_reg  <= {dq_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg  <= {dq_reg[62:0], 1'b0};
            end
        end
    end

    // add the quotient to the lower entry, or subtract it for a falling segment, and saturate
    always_comb
    begin
        sum = neg_reg ? (34'(y1_reg) - 34'(dq_reg[31:0]))
                      : (34'(y1_reg) + 34'(dq_reg[31:0]));
        if (sum > 34'sh0_7FFF_FFFF)
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum < -34'sh0_8000_0000)
            sum_sat = -32'sh8000_0000;
        else
            sum_sat = 32'(sum);
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            case (cmd.res_kind)
                RES_EMPTY:
                begin
                    res_status_reg <= ST_EMPTY;
                    res_value_reg  <= '0;
                end
                RES_NOT_FOUND:
                begin
                    res_status_reg <= ST_NOT_FOUND;
                    res_value_reg  <= '0;
                end
                RES_ENTRY:
                begin
                    res_status_reg <= ST_OK;
                    res_value_reg  <= ent_q;
                end
                RES_INTERP:
                begin
                    res_status_reg <= ST_OK;
                    res_value_reg  <= sum_sat;
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                    res_value_reg  <= '0;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_reg.status       <= res_status_reg;
            out_reg.result_value <= res_value_reg;
        end
    end

    assign rsp = out_reg;

    // status back to the controller
    always_comb
    begin
        stat.req_type  = req.req_type;
        stat.empty     = (nr == '0) || (nc == '0);
        stat.age_match = age_q == item_reg.query_age;
        stat.row_last  = (9'(row_reg) + 9'd1) == 9'(nr);
        stat.v_le_bp   = item_reg.query_value <= bp_q;
        stat.v_ge_bp   = item_reg.query_value >= bp_q;
        stat.v_eq_bp   = item_reg.query_value == bp_q;
        stat.div_done  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    end

endmodule

// ===== hdl/rkli_ctrl.sv =====
// controller: sequences writes, row search, breakpoint search and division
module rkli_ctrl import rkli_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = (stat.req_type == REQ_LOOKUP) ? S_CHECK : S_RESP;
            S_CHECK:
                state_next = stat.empty ? S_RESP : S_ROW_RD;
            S_ROW_RD:
                state_next = S_ROW_CMP;
            S_ROW_CMP:
                if (stat.age_match)
                    state_next = S_BP_FIRST;
                else if (stat.row_last)
                    state_next = S_RESP;
                else
                    state_next = S_ROW_RD;
            S_BP_FIRST:
                state_next = stat.v_le_bp ? S_EXACT_RD : S_BP_LAST;
            S_BP_LAST:
                state_next = stat.v_ge_bp ? S_EXACT_RD : S_SCAN_RD;
            S_SCAN_RD:
                state_next = S_SCAN_CMP;
            S_SCAN_CMP:
                if (stat.v_eq_bp)
                    state_next = S_EXACT_RD;
                else if (stat.v_le_bp)
                    state_next = S_Y1_RD;
                else
                    state_next = S_SCAN_RD;
            S_EXACT_RD:
                state_next = S_EXACT;
            S_EXACT:
                state_next = S_RESP;
            S_Y1_RD:
                state_next = S_Y2_RD;
            S_Y2_RD:
                state_next = S_MUL;
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (stat.div_done)
                    state_next = S_SUM;
            S_SUM:
                state_next = S_RESP;
            S_RESP:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands to the datapath and handshake outputs
    always_comb
    begin
        cmd            = '0;
        cmd.bp_sel     = BP_SCAN;
        cmd.res_kind   = RES_WRITE;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture  = 1'b1;
                    cmd.wr       = stat.req_type != REQ_LOOKUP;
                    cmd.res_set  = stat.req_type != REQ_LOOKUP;
                    cmd.res_kind = RES_WRITE;
                end
            end
            S_CHECK:
            begin
                cmd.row_init = 1'b1;
                cmd.res_set  = stat.empty;
                cmd.res_kind = RES_EMPTY;
            end
            S_ROW_RD:
                cmd.row_rd = 1'b1;
            S_ROW_CMP:
            begin
                if (stat.age_match)
                begin
                    cmd.bp_rd  = 1'b1;
                    cmd.bp_sel = BP_FIRST;
                end
                else if (stat.row_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_NOT_FOUND;
                end
                else
                    cmd.row_next = 1'b1;
            end
            S_BP_FIRST:
            begin
                cmd.save_x1 = 1'b1;
                if (stat.v_le_bp)
                    cmd.col_first = 1'b1;
                else
                begin
                    cmd.bp_rd  = 1'b1;
                    cmd.bp_sel = BP_LAST;
                end
            end
            S_BP_LAST:
            begin
                cmd.col_last = stat.v_ge_bp;
                cmd.col_one  = !stat.v_ge_bp;
            end
            S_SCAN_RD:
                cmd.bp_rd = 1'b1;
            S_SCAN_CMP:
            begin
                if (!stat.v_eq_bp && stat.v_le_bp)
                    cmd.save_x2 = 1'b1;
                else if (!stat.v_le_bp)
                begin
                    cmd.save_x1  = 1'b1;
                    cmd.col_next = 1'b1;
                end
            end
            S_EXACT_RD:
                cmd.ent_rd = 1'b1;
            S_EXACT:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_ENTRY;
            end
            S_Y1_RD:
            begin
                cmd.ent_rd   = 1'b1;
                cmd.ent_prev = 1'b1;
            end
            S_Y2_RD:
            begin
                cmd.save_y1 = 1'b1;
                cmd.ent_rd  = 1'b1;
            end
            // upper entry is on the read port, load the product into the divider
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_DIV:
                cmd.div_step = 1'b1;
            S_SUM:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = RES_INTERP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
                cmd.bp_sel = BP_SCAN;
        endcase
    end

endmodule

// ===== hdl/row_keyed_linear_interp_lookup.sv =====
// top level of the row keyed piecewise linear interpolation lookup
// Holds an age-keyed table of up to MAX_ROWS rows by MAX_COLUMNS breakpoint columns, loaded
// one age, breakpoint or entry per request, and answers requests one at a time with one
// response per request. A write goes straight to the response state, which loads the result
// into the output register once that register is free and then returns to idle. A lookup
// first checks the row and column counts, then reads and compares the age store row by row;
// after the matching row it clamps to the first or last entry, or scans the breakpoints for
// an exact hit or for the segment to interpolate with the restoring divider.
// The next request is taken while the previous response still waits in the output register.
// Reading an age, breakpoint or entry that was never written gives an undefined result.
`include "assert_macros.svh"

module row_keyed_linear_interp_lookup import rkli_pkg::*; #(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_item_t  req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    // sequencer
    rkli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // stores and arithmetic
    rkli_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

    // a transfer in makes the block busy in the next cycle
    `RKLI_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready, "still ready")
    // a loaded result is offered on the next cycle
    `RKLI_ASSERT_NEXT(a_load_shows, cmd.load_out, rsp_valid, "loaded result not valid")
    // at most one store read per cycle
    `RKLI_ASSERT(a_one_read, $onehot0({cmd.row_rd, cmd.bp_rd, cmd.ent_rd}), "several store reads")

endmodule
